### design/modexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

  // status of the bit-serial modular multiplier as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

endpackage

`default_nettype wire

### design/modexp_mulmod.sv
`timescale 1ns / 1ps
`default_nettype none

module modexp_mulmod #(
  parameter int unsigned W = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [W-1:0]             a_i,
  input  wire logic [W-1:0]             b_i,
  input  wire logic [W-1:0]             m_i,
  output logic [W-1:0]                  result_o,
  output modexp_pkg::mm_status_t        status_o
);
  import modexp_pkg::*;

  localparam int unsigned CntW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0]    a_q, a_d, b_q, b_d, acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;

  logic [W:0]   dbl, dbl_sub, sum, sum_sub;
  logic [W-1:0] dbl_mod, step_acc;

  // one multiplier bit per cycle, msb first: acc = 2*acc + bit*b, reduced twice
  always_comb begin
    dbl      = {acc_q, 1'b0};
    dbl_sub  = dbl - {1'b0, m_i};
    dbl_mod  = (dbl >= {1'b0, m_i}) ? dbl_sub[W-1:0] : dbl[W-1:0];
    sum      = {1'b0, dbl_mod} + (a_q[W-1] ? {1'b0, b_q} : {(W+1){1'b0}});
    sum_sub  = sum - {1'b0, m_i};
    step_acc = (sum >= {1'b0, m_i}) ? sum_sub[W-1:0] : sum[W-1:0];
  end

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
      cnt_d  = CntW'(W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = step_acc;
      a_d   = {a_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign result_o = acc_q;
  assign status_o = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

### design/modular_exponentiation.sv
`timescale 1ns / 1ps
`default_nettype none

// Modular exponentiation: each base word gives base^exponent mod modulus, with
// exponent and modulus taken from the APB registers (exponent at index 0,
// modulus at index 1, both reset to 1). The base is reduced first, then every
// exponent bit from the msb down squares the running value and, where the bit
// is set, multiplies it by the reduced base. All multiplications run through
// one bit-serial modular multiplier; a modulus of zero gives a result of 0.
// One item is in work at a time; a finished word waits in the output register
// while the next base is accepted. Write registers only while the block is
// idle.
module modular_exponentiation #(
  parameter int unsigned OPERAND_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [OPERAND_BITS-1:0]       base_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [OPERAND_BITS-1:0]            power_mod_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [((OPERAND_BITS > 32) ? 4 : 3)-1:0]   paddr,
  input  wire logic [((OPERAND_BITS > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((OPERAND_BITS > 32) ? 64 : 32)-1:0]      prdata,
  output logic                               pready
);
  import modexp_pkg::*;

  localparam int unsigned W     = OPERAND_BITS;
  localparam int unsigned AddrW = (OPERAND_BITS > 32) ? 4 : 3;
  localparam int unsigned DataW = (OPERAND_BITS > 32) ? 64 : 32;
  localparam int unsigned IdxW  = $clog2(OPERAND_BITS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RED  = 3'd1;
  localparam logic [2:0] ST_SQR  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [W-1:0]    exponent_q, modulus_q;
  logic [W-1:0]    base_q, base_d, r_q, r_d, out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic            out_load;

  logic            mm_start;
  logic [W-1:0]    mm_a, mm_b, mm_result, one_mod;
  mm_status_t      mm_status;
  logic            cfg_wr;

  // apb registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[AddrW-1] ? DataW'(modulus_q) : DataW'(exponent_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= W'(1);
      modulus_q  <= W'(1);
    end else if (cfg_wr) begin
      if (paddr[AddrW-1]) begin
        modulus_q <= pwdata[W-1:0];
      end else begin
        exponent_q <= pwdata[W-1:0];
      end
    end
  end

  assign one_mod    = (modulus_q == W'(1)) ? '0 : W'(1);
  assign in_ready_o = (state_q == ST_IDLE) && !mm_status.busy;

  modexp_mulmod #(
    .W(W)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .m_i     (modulus_q),
    .result_o(mm_result),
    .status_o(mm_status)
  );

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    base_d   = base_q;
    r_d      = r_q;
    mm_start = 1'b0;
    mm_a     = mm_result;
    mm_b     = mm_result;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (modulus_q == '0) begin
            r_d     = '0;
            state_d = ST_FIN;
          end else begin
            // base mod m as base * (1 mod m)
            mm_start = 1'b1;
            mm_a     = base_i;
            mm_b     = one_mod;
            state_d  = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (mm_status.done) begin
          base_d   = mm_result;
          r_d      = one_mod;
          mm_start = 1'b1;
          mm_a     = one_mod;
          mm_b     = one_mod;
          idx_d    = IdxW'(W - 1);
          state_d  = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mm_status.done) begin
          r_d = mm_result;
          if (exponent_q[idx_q]) begin
            mm_start = 1'b1;
            mm_b     = base_q;
            state_d  = ST_MUL;
          end else if (idx_q == '0) begin
            state_d = ST_FIN;
          end else begin
            idx_d    = idx_q - 1'b1;
            mm_start = 1'b1;
          end
        end
      end
      ST_MUL: begin
        if (mm_status.done) begin
          r_d = mm_result;
          if (idx_q == '0) begin
            state_d = ST_FIN;
          end else begin
            idx_d    = idx_q - 1'b1;
            mm_start = 1'b1;
            state_d  = ST_SQR;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_d       = r_q;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    r_q    <= r_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign power_mod_o = out_q;

endmodule

`default_nettype wire

### design/modexp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module modexp_checker #(
  parameter int unsigned W = 32
) (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         in_valid_i,
  input wire logic         in_ready_o,
  input wire logic         out_valid_o,
  input wire logic         out_ready_i,
  input wire logic [W-1:0] power_mod_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(power_mod_o))
    else $error("result word changed while stalled");

  // one item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in work");

  // a new result returns the block to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result presented while still busy");

endmodule

bind modular_exponentiation modexp_checker #(
  .W(OPERAND_BITS)
) u_modexp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .power_mod_o(power_mod_o)
);

`default_nettype wire
